/* hdl/light_sensor_brightness_spread_top_assert.svh */
// Assertion macros for the light sensor brightness spread block.
// Used by the port checker; needs nothing else.
`ifndef LIGHT_SENSOR_BRIGHTNESS_SPREAD_TOP_ASSERT_SVH
`define LIGHT_SENSOR_BRIGHTNESS_SPREAD_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LSBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LSBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lsbs_pkg.sv */
// Shared types, constants and tables of the light sensor brightness spread block.
// No dependencies.
package lsbs_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int IDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CNT_W   = $clog2(SENSOR_COUNT + 1);
    localparam int DIST_W  = IDX_W + 1;
    localparam int ACC_W   = IDX_W + 9;
    localparam int RD_W    = 12;
    localparam int LVL_W   = 7;
    localparam int PIX_W   = 6;
    localparam int COL_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W  = RECIP_SHIFT + 1;
    // power of two so the queue pointers wrap on their own
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W = $clog2(CMDQ_DEPTH);

    localparam logic [LVL_W-1:0] LVL_MAX = 7'd100;
    localparam logic [LVL_W-1:0] LVL_MIN = 7'd1;

    typedef enum logic [1:0] {
        MODE_AUTO = 2'd0,
        MODE_OFF  = 2'd1,
        MODE_ON   = 2'd2,
        MODE_ALT  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_MODE = 3'd0,
        CFG_INVERT     = 3'd1,
        CFG_FULL_SCALE = 3'd2,
        CFG_DIVISOR    = 3'd3,
        CFG_WEIGHT     = 3'd4,
        CFG_COLUMNS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       light_mode;
        logic             invert_reading;
        logic [RD_W-1:0]  adc_full_scale;
        logic [RD_W-1:0]  level_divisor;
        logic [7:0]       spread_weight;
        logic [COL_W-1:0] grid_columns;
    } t_cfg;

    // front to back work item
    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] level;
        logic             frame_end;
    } t_cmd;

    // ceil(2^16 / d); exact quotient for dividends below 256 and d below 16
    typedef logic [2**DIST_W-1:0][RECIP_W-1:0] t_recip_tab;

    // table built at elaboration by shift-and-subtract
    function automatic t_recip_tab f_recip_tab();
        t_recip_tab tab;
        int rem;
        int q;
        tab[0] = RECIP_W'(2**RECIP_SHIFT);
        for (int k = 1; k < 2**DIST_W; k++) begin
            rem = 2**RECIP_SHIFT + k - 1;
            q = 0;
            for (int b = RECIP_SHIFT; b >= 0; b--) begin
                if (rem >= (k << b)) begin
                    rem = rem - (k << b);
                    q = q + (1 << b);
                end
            end
            tab[k] = RECIP_W'(q);
        end
        return tab;
    endfunction

    localparam t_recip_tab RECIP_TAB = f_recip_tab();

endpackage

/* hdl/lsbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lsbs_front.sv */
// Front end: accepts readings, counts the frame, turns a reading into a level.
// Depends on lsbs_pkg.
module lsbs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [lsbs_pkg::RD_W-1:0]   i_reading,
    input  logic                        i_frame_end,
    input  lsbs_pkg::t_cfg              i_cfg,
    output lsbs_pkg::t_cmd              o_cmd,
    output logic                        o_cmd_vld,
    input  logic                        i_cmd_full
);
    import lsbs_pkg::*;

    localparam int NUM_W   = RD_W + 2;
    localparam int DEN_W   = RD_W + 1;
    localparam int TRIAL_W = DEN_W + 7;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate            r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_wr;
    logic               r_fe;
    logic [IDX_W-1:0]   r_idx;
    logic [NUM_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [2:0]         r_step;
    logic [7:0]         r_q;

    logic               accept;
    logic               has_slot;
    logic               do_wr;
    logic [RD_W-1:0]    inv_val;
    logic [RD_W-1:0]    val;
    logic [RD_W-1:0]    div_d;
    logic [TRIAL_W-1:0] trial;
    logic               fits;
    logic [LVL_W-1:0]   q_lvl;

    always_comb begin
        accept   = i_push && (r_state == F_IDLE);
        has_slot = r_count < CNT_W'(SENSOR_COUNT);
        do_wr    = has_slot && (t_mode'(i_cfg.light_mode) == MODE_AUTO);
        inv_val  = (i_cfg.adc_full_scale >= i_reading) ?
                   i_cfg.adc_full_scale - i_reading : '0;
        val      = i_cfg.invert_reading ? inv_val : i_reading;
        div_d    = (i_cfg.level_divisor == '0) ? RD_W'(1) : i_cfg.level_divisor;
        trial    = TRIAL_W'(r_den) << r_step;
        fits     = TRIAL_W'(r_rem) >= trial;
        // bit 7 set means the quotient is at least 128
        q_lvl    = (r_q[7] || (r_q[6:0] > LVL_MAX)) ? LVL_MAX : r_q[6:0];
    end

    assign o_full    = (r_state != F_IDLE);
    assign o_cmd_vld = (r_state == F_PUSH);
    assign o_cmd     = '{wr: r_wr, idx: r_idx, level: q_lvl, frame_end: r_fe};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_wr   <= do_wr;
                        r_fe   <= i_frame_end;
                        r_idx  <= r_count[IDX_W-1:0];
                        // round half up: (2v + d) / (2d)
                        r_rem  <= {1'b0, val, 1'b0} + NUM_W'(div_d);
                        r_den  <= {div_d, 1'b0};
                        r_step <= 3'd7;
                        r_q    <= '0;
                        if (i_frame_end) begin
                            r_count <= '0;
                        end else if (has_slot) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (do_wr) begin
                            r_state <= F_DIV;
                        end else if (i_frame_end) begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    if (fits) begin
                        r_rem         <= r_rem - trial[NUM_W-1:0];
                        r_q[r_step]   <= 1'b1;
                    end
                    r_step <= r_step - 3'd1;
                    if (r_step == 3'd0) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/lsbs_cmd_q.sv */
// Short command queue between front end and back end.
// Depends on lsbs_pkg.
module lsbs_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsbs_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output lsbs_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import lsbs_pkg::*;

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/lsbs_back.sv */
// Back end: level store, neighbor spreading and per-pixel result emission.
// Depends on lsbs_pkg and lsbs_ram.
module lsbs_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lsbs_pkg::t_cfg               i_cfg,
    input  lsbs_pkg::t_cmd               i_cmd,
    input  logic                         i_cmd_empty,
    output logic                         o_cmd_pop,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [lsbs_pkg::PIX_W-1:0]   o_pixel_index,
    output logic [lsbs_pkg::LVL_W-1:0]   o_pixel_level,
    output logic                         o_last_pixel
);
    import lsbs_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

    typedef enum logic [1:0] {B_IDLE, B_SPREAD, B_EMIT_RD, B_EMIT_WR} t_bstate;

    t_bstate             r_state;
    // sensor being updated and its grid position
    logic [IDX_W-1:0]    r_src;
    logic [IDX_W-1:0]    r_scol;
    logic [IDX_W-1:0]    r_srow;
    // neighbor being read and its grid position
    logic [IDX_W-1:0]    r_nbr;
    logic [IDX_W-1:0]    r_ncol;
    logic [IDX_W-1:0]    r_nrow;
    logic                r_issue;
    logic                r_a_vld;
    logic                r_a_self;
    logic                r_a_last;
    logic [DIST_W-1:0]   r_a_dist;
    logic                r_b_vld;
    logic                r_b_self;
    logic                r_b_last;
    logic [LVL_W-1:0]    r_b_lvl;
    logic [7:0]          r_b_y;
    logic [RECIP_W-1:0]  r_b_recip;
    logic                r_c_done;
    logic [ACC_W-1:0]    r_acc;
    logic [IDX_W-1:0]    r_pix;
    logic                r_out_vld;
    logic [PIX_W-1:0]    r_out_idx;
    logic [LVL_W-1:0]    r_out_lvl;
    logic                r_out_last;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [LVL_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [LVL_W-1:0]    ram_rdata;

    t_mode               mode;
    logic [COL_W-1:0]    cols;
    logic                ncol_wrap;
    logic                scol_wrap;
    logic [IDX_W-1:0]    dx;
    logic [IDX_W-1:0]    dy;
    logic                issue_now;
    logic [14:0]         b_prod;
    logic [15:0]         b_num;
    logic [24:0]         c_prod;
    logic [8:0]          term;
    logic [ACC_W-1:0]    acc_add;
    logic [LVL_W-1:0]    acc_sat;
    logic [LVL_W-1:0]    man_lvl;
    logic [LVL_W-1:0]    raw_lvl;
    logic [LVL_W-1:0]    emit_lvl;
    logic                out_free;

    always_comb begin
        mode      = t_mode'(i_cfg.light_mode);
        cols      = (i_cfg.grid_columns == '0) ? COL_W'(1) : i_cfg.grid_columns;
        ncol_wrap = (COL_W'(r_ncol) + COL_W'(1)) == cols;
        scol_wrap = (COL_W'(r_scol) + COL_W'(1)) == cols;
        dx        = (r_scol >= r_ncol) ? r_scol - r_ncol : r_ncol - r_scol;
        dy        = (r_srow >= r_nrow) ? r_srow - r_nrow : r_nrow - r_srow;
        issue_now = (r_state == B_SPREAD) && r_issue;

        // floor((2*w*L + 256*D) / 512) first, then divide by D
        b_prod    = i_cfg.spread_weight * ram_rdata;
        b_num     = {1'b0, b_prod} + 16'({r_a_dist, 7'b0});
        c_prod    = r_b_y * r_b_recip;
        term      = c_prod[24:RECIP_SHIFT];
        acc_add   = r_b_self ? ACC_W'(r_b_lvl) : ACC_W'(term);
        acc_sat   = (r_acc > ACC_W'(LVL_MAX)) ? LVL_MAX : r_acc[LVL_W-1:0];

        // unused mode code behaves as manual on
        man_lvl   = (mode == MODE_OFF) ? LVL_MIN : LVL_MAX;
        raw_lvl   = (mode == MODE_AUTO) ? ram_rdata : man_lvl;
        emit_lvl  = (raw_lvl < LVL_MIN) ? LVL_MIN :
                    (raw_lvl > LVL_MAX) ? LVL_MAX : raw_lvl;
        out_free  = !r_out_vld || i_pop;

        o_cmd_pop = (r_state == B_IDLE) && !i_cmd_empty;
        ram_we    = (o_cmd_pop && i_cmd.wr) || ((r_state == B_SPREAD) && r_c_done);
        ram_waddr = (r_state == B_SPREAD) ? r_src : i_cmd.idx;
        ram_wdata = (r_state == B_SPREAD) ? acc_sat : i_cmd.level;
        ram_re    = issue_now || (r_state == B_EMIT_RD);
        ram_raddr = (r_state == B_SPREAD) ? r_nbr : r_pix;
    end

    lsbs_ram #(
        .WIDTH (LVL_W),
        .DEPTH (SENSOR_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_empty       = !r_out_vld;
    assign o_pixel_index = r_out_idx;
    assign o_pixel_level = r_out_lvl;
    assign o_last_pixel  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_issue   <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_done  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // spread pipeline: read, weight, divide and accumulate
            r_a_vld   <= issue_now;
            r_a_self  <= (r_nbr == r_src);
            r_a_last  <= (r_nbr == LAST_IDX);
            r_a_dist  <= DIST_W'(dx) + DIST_W'(dy);
            r_b_vld   <= r_a_vld;
            r_b_self  <= r_a_self;
            r_b_last  <= r_a_last;
            r_b_lvl   <= ram_rdata;
            r_b_y     <= b_num[15:8];
            r_b_recip <= RECIP_TAB[r_a_dist];
            r_c_done  <= r_b_vld && r_b_last;
            if (r_b_vld) begin
                r_acc <= r_acc + acc_add;
            end
            if (issue_now) begin
                r_nbr <= r_nbr + IDX_W'(1);
                if (ncol_wrap) begin
                    r_ncol <= '0;
                    r_nrow <= r_nrow + IDX_W'(1);
                end else begin
                    r_ncol <= r_ncol + IDX_W'(1);
                end
                if (r_nbr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end
            end

            if (r_out_vld && i_pop) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                B_IDLE: begin
                    if (o_cmd_pop && i_cmd.frame_end) begin
                        r_src  <= '0;
                        r_scol <= '0;
                        r_srow <= '0;
                        r_nbr  <= '0;
                        r_ncol <= '0;
                        r_nrow <= '0;
                        r_acc  <= '0;
                        r_pix  <= '0;
                        if (mode == MODE_AUTO) begin
                            r_issue <= 1'b1;
                            r_state <= B_SPREAD;
                        end else begin
                            r_state <= B_EMIT_RD;
                        end
                    end
                end
                B_SPREAD: begin
                    // sum done: store written back this cycle
                    if (r_c_done) begin
                        r_acc  <= '0;
                        r_nbr  <= '0;
                        r_ncol <= '0;
                        r_nrow <= '0;
                        if (r_src == LAST_IDX) begin
                            r_pix   <= '0;
                            r_state <= B_EMIT_RD;
                        end else begin
                            r_src   <= r_src + IDX_W'(1);
                            r_issue <= 1'b1;
                            if (scol_wrap) begin
                                r_scol <= '0;
                                r_srow <= r_srow + IDX_W'(1);
                            end else begin
                                r_scol <= r_scol + IDX_W'(1);
                            end
                        end
                    end
                end
                B_EMIT_RD: begin
                    r_state <= B_EMIT_WR;
                end
                B_EMIT_WR: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_idx  <= PIX_W'(r_pix);
                        r_out_lvl  <= emit_lvl;
                        r_out_last <= (r_pix == LAST_IDX);
                        if (r_pix == LAST_IDX) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_pix   <= r_pix + IDX_W'(1);
                            r_state <= B_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/light_sensor_brightness_spread_top.sv */
// Top level of the light sensor brightness spread block: configuration registers,
// front end, command queue and back end. Depends on lsbs_pkg, lsbs_front, lsbs_cmd_q and lsbs_back.
//
// Readings enter one per push; when the reading flagged frame_end is taken the block
// produces SENSOR_COUNT results, pixel 0 first, the last one flagged last_pixel. In
// automatic mode a reading that lands in the store holds full high after it is taken,
// through each step of the restoring divider that forms the level and until the level
// is handed to the queue, so the next reading waits until then; readings in manual mode
// or beyond SENSOR_COUNT are taken every cycle, but one with frame_end holds full high
// until it is handed to the queue. At frame end in automatic mode the back end spreads
// the levels, reading the neighbors one at a time through the single read port of the
// level store, then emits each pixel through B_EMIT_RD and B_EMIT_WR while pop keeps
// up; the next frame's readings are taken in the meantime until the two-entry command
// queue fills. Pixels never stored read back undefined.
module light_sensor_brightness_spread_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [lsbs_pkg::RD_W-1:0]           i_reading,
    input  logic                                i_frame_end,
    input  logic                                i_cfg_we,
    input  logic [lsbs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lsbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                empty,
    input  logic                                pop,
    output logic [lsbs_pkg::PIX_W-1:0]          o_pixel_index,
    output logic [lsbs_pkg::LVL_W-1:0]          o_pixel_level,
    output logic                                o_last_pixel
);
    import lsbs_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_vld;
    logic q_full;
    logic q_empty;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_mode     <= MODE_AUTO;
            r_cfg.invert_reading <= 1'b1;
            r_cfg.adc_full_scale <= 12'd1023;
            r_cfg.level_divisor  <= 12'd10;
            r_cfg.spread_weight  <= 8'd64;
            r_cfg.grid_columns   <= 7'd4;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LIGHT_MODE: r_cfg.light_mode     <= i_cfg_data[1:0];
                CFG_INVERT:     r_cfg.invert_reading <= i_cfg_data[0];
                CFG_FULL_SCALE: r_cfg.adc_full_scale <= i_cfg_data;
                CFG_DIVISOR:    r_cfg.level_divisor  <= i_cfg_data;
                CFG_WEIGHT:     r_cfg.spread_weight  <= i_cfg_data[7:0];
                CFG_COLUMNS:    r_cfg.grid_columns   <= i_cfg_data[COL_W-1:0];
                default:        r_cfg                <= r_cfg;
            endcase
        end
    end

    lsbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_reading   (i_reading),
        .i_frame_end (i_frame_end),
        .i_cfg       (r_cfg),
        .o_cmd       (front_cmd),
        .o_cmd_vld   (front_vld),
        .i_cmd_full  (q_full)
    );

    lsbs_cmd_q u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    lsbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (q_cmd),
        .i_cmd_empty   (q_empty),
        .o_cmd_pop     (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_index (o_pixel_index),
        .o_pixel_level (o_pixel_level),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

/* hdl/lsbs_checker.sv */
// Port-level checker for the light sensor brightness spread block, bound to the top.
// Depends on lsbs_pkg and the assertion macro header.
`include "light_sensor_brightness_spread_top_assert.svh"

module lsbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [lsbs_pkg::PIX_W-1:0]    o_pixel_index,
    input logic [lsbs_pkg::LVL_W-1:0]    o_pixel_level,
    input logic                          o_last_pixel
);
    import lsbs_pkg::*;

    localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(SENSOR_COUNT - 1);

    // index the next result beat must carry
    logic [PIX_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (pop && !empty) begin
            r_exp_idx <= o_last_pixel ? '0 : r_exp_idx + PIX_W'(1);
        end
    end

    `LSBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_pixel_index) && $stable(o_pixel_level) && $stable(o_last_pixel), "result beat changed while stalled")
    `LSBS_ASSERT_NOW(a_level_range, i_clk, i_rst_n, !empty, o_pixel_level >= LVL_MIN && o_pixel_level <= LVL_MAX, "pixel level out of range")
    `LSBS_ASSERT_NOW(a_last_flag, i_clk, i_rst_n, !empty, o_last_pixel == (o_pixel_index == LAST_PIX), "last pixel flag mismatch")
    `LSBS_ASSERT_NOW(a_idx_order, i_clk, i_rst_n, !empty, o_pixel_index == r_exp_idx, "pixel index out of order")

endmodule

bind light_sensor_brightness_spread_top lsbs_checker u_chk (.*);

/* tb/testbench.sv */
// Self-checking bench for light_sensor_brightness_spread_top: readings go in as push beats,
// pixels are popped and compared against a predictor kept inside this file.
// Depends on lsbs_pkg and the RTL under hdl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbs_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int ITEM_TARGET = 310;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 16;
    localparam int DRAIN       = 120;
    localparam int DIR_ROWS    = 37;
    localparam int TIMEOUT_NS  = 10_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] idx;
        logic [LVL_W-1:0] lvl;
        logic             last;
    } pixel_t;

    // one directed step: a register write or a reading; want = 0 means predicted
    typedef struct {
        bit               is_cfg;
        t_cfg_idx         cfg_idx;
        logic [RD_W-1:0]  value;
        bit               fend;
        logic [LVL_W-1:0] want;
    } step_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [RD_W-1:0]       i_reading;
    logic                  i_frame_end;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  empty;
    logic                  pop;
    logic [PIX_W-1:0]      o_pixel_index;
    logic [LVL_W-1:0]      o_pixel_level;
    logic                  o_last_pixel;

    light_sensor_brightness_spread_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_reading     (i_reading),
        .i_frame_end   (i_frame_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_index (o_pixel_index),
        .o_pixel_level (o_pixel_level),
        .o_last_pixel  (o_last_pixel)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    t_mode            m_mode;
    logic             m_invert;
    logic [RD_W-1:0]  m_full;
    logic [RD_W-1:0]  m_div;
    logic [7:0]       m_weight;
    logic [COL_W-1:0] m_cols;
    logic [LVL_W-1:0] pct_mem [SENSOR_COUNT];
    int               rd_seen;

    pixel_t pending_pixels [$];
    int     err_cnt = 0;
    bit     tx_steady = 1'b0;
    bit     hold_req = 1'b0;
    step_t  dir_tab [DIR_ROWS];

    task automatic report_err(string msg);
        err_cnt++;
        if (err_cnt <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_value(int e0, int e1, int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return e0;
        if (r < 40) return e1;
        return $urandom_range(hi, lo);
    endfunction

    function automatic step_t cfg_row(t_cfg_idx idx, int val);
        step_t s;
        s.is_cfg = 1'b1;
        s.cfg_idx = idx;
        s.value = RD_W'(val);
        s.fend = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t item_row(int rd, bit fe, int want);
        step_t s;
        s.is_cfg = 1'b0;
        s.cfg_idx = CFG_LIGHT_MODE;
        s.value = RD_W'(rd);
        s.fend = fe;
        s.want = LVL_W'(want);
        return s;
    endfunction

    function automatic void reset_predictor();
        m_mode = MODE_AUTO;
        m_invert = 1'b1;
        m_full = 12'd1023;
        m_div = 12'd10;
        m_weight = 8'd64;
        m_cols = 7'd4;
        rd_seen = 0;
        for (int s = 0; s < SENSOR_COUNT; s++) pct_mem[s] = '0;
    endfunction

    function automatic int unsigned reading_to_percent(logic [RD_W-1:0] rd);
        int unsigned v, d, lvl;
        v = rd;
        d = (m_div == 0) ? 1 : m_div;
        if (m_invert) v = (m_full >= rd) ? int'(m_full) - int'(rd) : 0;
        lvl = (2 * v + d) / (2 * d);
        return (lvl > LVL_MAX) ? LVL_MAX : lvl;
    endfunction

    function automatic int unsigned sensor_hops(int a, int b);
        int c, dx, dy;
        c = (m_cols == 0) ? 1 : m_cols;
        dx = (a % c) - (b % c);
        dy = (a / c) - (b / c);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return dx + dy;
    endfunction

    // in-place pass: sensors later in index order already see updated neighbors
    function automatic void blend_neighbors();
        int unsigned acc, hops, w, l;
        w = m_weight;
        for (int s = 0; s < SENSOR_COUNT; s++) begin
            acc = pct_mem[s];
            for (int n = 0; n < SENSOR_COUNT; n++) begin
                if (n != s) begin
                    hops = sensor_hops(s, n);
                    if (hops == 0) hops = 1;
                    l = pct_mem[n];
                    acc += (2 * w * l + 256 * hops) / (512 * hops);
                end
            end
            pct_mem[s] = LVL_W'((acc > LVL_MAX) ? LVL_MAX : acc);
        end
    endfunction

    function automatic void accept_reading(logic [RD_W-1:0] rd, bit fend,
                                           logic [LVL_W-1:0] want);
        pixel_t px;
        int unsigned lvl;
        if (rd_seen < SENSOR_COUNT) begin
            if (m_mode == MODE_AUTO) pct_mem[rd_seen] = LVL_W'(reading_to_percent(rd));
            rd_seen++;
        end
        if (fend) begin
            if (m_mode == MODE_AUTO) blend_neighbors();
            for (int p = 0; p < SENSOR_COUNT; p++) begin
                if (m_mode == MODE_AUTO) lvl = pct_mem[p];
                else lvl = (m_mode == MODE_OFF) ? LVL_MIN : LVL_MAX;
                if (lvl < LVL_MIN) lvl = LVL_MIN;
                if (lvl > LVL_MAX) lvl = LVL_MAX;
                if (want != 0) lvl = want;
                px.idx = PIX_W'(p);
                px.lvl = LVL_W'(lvl);
                px.last = (p == SENSOR_COUNT - 1);
                pending_pixels.push_back(px);
            end
            rd_seen = 0;
        end
    endfunction

    function automatic logic [RD_W-1:0] pick_reading();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 40) return RD_W'($urandom_range(0, m_full));
        return RD_W'($urandom_range(0, 4095));
    endfunction

    task automatic check_pixel();
        pixel_t px;
        if (pending_pixels.size() == 0) begin
            report_err($sformatf("pixel %0d level %0d popped with nothing expected",
                                 o_pixel_index, o_pixel_level));
        end else begin
            px = pending_pixels.pop_front();
            if (o_pixel_index !== px.idx)
                report_err($sformatf("pixel index %0d, expected %0d", o_pixel_index, px.idx));
            if (o_pixel_level !== px.lvl)
                report_err($sformatf("pixel %0d level %0d, expected %0d",
                                     px.idx, o_pixel_level, px.lvl));
            if (o_last_pixel !== px.last)
                report_err($sformatf("pixel %0d last flag %0b, expected %0b",
                                     px.idx, o_last_pixel, px.last));
        end
    endtask

    // drop push and let the block drain before touching registers
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // caller lowers i_cfg_we after the last write of a batch
    task automatic write_reg(t_cfg_idx idx, logic [RD_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LIGHT_MODE: m_mode = t_mode'(val[1:0]);
            CFG_INVERT:     m_invert = val[0];
            CFG_FULL_SCALE: m_full = val;
            CFG_DIVISOR:    m_div = val;
            CFG_WEIGHT:     m_weight = val[7:0];
            CFG_COLUMNS:    m_cols = val[COL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_settings(bit force_auto);
        int mode;
        int cols;
        wait_idle();
        mode = (force_auto || $urandom_range(0, 99) < 55) ? int'(MODE_AUTO)
                                                          : $urandom_range(1, 3);
        cols = ($urandom_range(0, 9) == 0) ? 127 : pick_value(0, 64, 1, 9);
        write_reg(CFG_LIGHT_MODE, RD_W'(mode));
        write_reg(CFG_INVERT, RD_W'($urandom_range(0, 1)));
        write_reg(CFG_FULL_SCALE, RD_W'(pick_value(0, 4095, 0, 4095)));
        write_reg(CFG_DIVISOR, RD_W'(pick_value(0, 4095, 1, 60)));
        write_reg(CFG_WEIGHT, RD_W'(pick_value(0, 255, 0, 255)));
        write_reg(CFG_COLUMNS, RD_W'(cols));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(logic [RD_W-1:0] rd, bit fend, logic [LVL_W-1:0] want);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_reading <= rd;
        i_frame_end <= fend;
        do @(posedge i_clk); while (full);
        accept_reading(rd, fend, want);
    endtask

    // result side: random pop gaps, one long hold-off on request
    initial begin
        int hold_left;
        int pop_gap;
        int rx_cyc;
        bit rx_steady;
        bit hold_done;
        hold_left = 0;
        pop_gap = 0;
        rx_cyc = 0;
        rx_steady = 1'b0;
        hold_done = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (rx_cyc % 200 == 0) rx_steady = ($urandom_range(0, 3) == 0);
            if (pop && !empty) begin
                check_pixel();
                pop_gap = pick_gap(rx_steady);
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int n_items;
        int n_frames;
        int flen;
        int r;
        bit writing;
        bit squeezed;
        bit squeeze;
        bit fe;
        push <= 1'b0;
        i_reading <= '0;
        i_frame_end <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_LIGHT_MODE;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        n_items = 0;
        writing = 1'b0;
        squeezed = 1'b0;
        reset_predictor();

        // the first frame is full so every stored level is written before any spread
        dir_tab = '{
            item_row(0, 0, 0), item_row(0, 0, 0), item_row(0, 0, 0), item_row(0, 0, 0),
            item_row(0, 0, 0), item_row(0, 0, 0), item_row(0, 0, 0), item_row(0, 1, 100),
            // zero divisor, zero columns, heaviest weight
            cfg_row(CFG_INVERT, 0), cfg_row(CFG_DIVISOR, 0), cfg_row(CFG_COLUMNS, 0),
            cfg_row(CFG_WEIGHT, 255),
            item_row(4095, 1, 0),
            // reading above full scale, no spreading; short frame keeps old levels
            cfg_row(CFG_INVERT, 1), cfg_row(CFG_FULL_SCALE, 0), cfg_row(CFG_WEIGHT, 0),
            item_row(4095, 1, 0),
            // one row of 64 columns; last two readings overflow the frame
            cfg_row(CFG_FULL_SCALE, 4095), cfg_row(CFG_DIVISOR, 41),
            cfg_row(CFG_WEIGHT, 128), cfg_row(CFG_COLUMNS, 64),
            item_row(0, 0, 0), item_row(4095, 0, 0), item_row(2047, 0, 0),
            item_row(1, 0, 0), item_row(4094, 0, 0), item_row(100, 0, 0),
            item_row(2048, 0, 0), item_row(3000, 0, 0), item_row(0, 0, 0),
            item_row(4095, 1, 0),
            cfg_row(CFG_LIGHT_MODE, int'(MODE_OFF)), item_row(123, 1, 1),
            cfg_row(CFG_LIGHT_MODE, int'(MODE_ON)), item_row(4095, 1, 100),
            cfg_row(CFG_LIGHT_MODE, int'(MODE_ALT)), item_row(0, 1, 100)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            if (dir_tab[n].is_cfg) begin
                if (!writing) begin
                    wait_idle();
                    writing = 1'b1;
                end
                write_reg(dir_tab[n].cfg_idx, dir_tab[n].value);
            end else begin
                if (writing) begin
                    i_cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                if (rd_seen < SENSOR_COUNT || dir_tab[n].fend) n_items++;
                send_item(dir_tab[n].value, dir_tab[n].fend, dir_tab[n].want);
            end
        end

        while (n_items < ITEM_TARGET) begin
            // one auto phase with a long receiver hold so the input backs up
            squeeze = !squeezed && n_items >= 100;
            if (squeeze) squeezed = 1'b1;
            random_settings(squeeze);
            tx_steady = squeeze || ($urandom_range(0, 3) == 0);
            if (squeeze) hold_req = 1'b1;
            n_frames = squeeze ? 5 : $urandom_range(2, 5);
            for (int f = 0; f < n_frames; f++) begin
                if (f > 0 && !squeeze && $urandom_range(0, 9) == 0) wait_idle();
                r = $urandom_range(0, 99);
                if (squeeze || r < 65) flen = SENSOR_COUNT;
                else if (r < 85) flen = $urandom_range(1, SENSOR_COUNT - 1);
                else flen = $urandom_range(SENSOR_COUNT + 1, SENSOR_COUNT + 4);
                for (int k = 0; k < flen; k++) begin
                    fe = (k == flen - 1);
                    if (rd_seen < SENSOR_COUNT || fe) n_items++;
                    send_item(pick_reading(), fe, '0);
                end
            end
        end

        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench: done, errors");
        $finish;
    end

endmodule
